// ===== rtl/rta_pkg.sv =====
package rta_pkg;

  // Fixed geometry of the sample ring.
  localparam int RING_DEPTH = 4;
  localparam int RING_IDX_W = $clog2(RING_DEPTH);

  // Default sample width, handed to the top level as its parameter default.
  localparam int SAMPLE_BITS_DEF = 12;

  // Register and field widths.
  localparam int SETPOINT_W = 12;
  localparam int TIMEOUT_W  = 14;
  localparam int CFG_DATA_W = 14;
  localparam int DRIVE_W    = 8;
  localparam int GAIN_W     = 17;
  localparam int PERIOD_W   = 14;
  localparam int VOTE_W     = 3;
  localparam int CROSS_W    = 3;

  // Output word layout, lowest bit first.
  localparam int OUT_BITS    = DRIVE_W + 3 + GAIN_W + PERIOD_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Constants of the relay scheme.
  localparam logic [DRIVE_W-1:0]    DRIVE_HEAT     = 8'd237;
  localparam logic [DRIVE_W-1:0]    DRIVE_OFF      = 8'd40;
  localparam logic [GAIN_W-1:0]     GAIN_DEFAULT   = 17'd256;
  localparam logic [GAIN_W-1:0]     GAIN_NUMERATOR = 17'd130048;
  localparam logic [PERIOD_W-1:0]   PERIOD_DEFAULT = 14'd40;
  localparam logic [VOTE_W-1:0]     VOTE_LIMIT     = 3'd4;
  localparam logic [SETPOINT_W-1:0] SETPOINT_RESET = 12'd200;
  localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RESET  = 14'd10800;
  localparam logic [PERIOD_W-1:0]   CROSS_LAG      = 14'd3;

  // Crossing counts that matter.
  localparam logic [CROSS_W-1:0] CROSS_RING_A = 3'd3;
  localparam logic [CROSS_W-1:0] CROSS_RING_B = 3'd4;
  localparam logic [CROSS_W-1:0] CROSS_FINAL  = 3'd5;

  // Register indexes on the configuration channel.
  localparam logic REG_SETPOINT = 1'b0;
  localparam logic REG_TIMEOUT  = 1'b1;

  // Request kinds carried in tuser.
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RING,
    S_DIV,
    S_OUT
  } rta_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } rta_div_status_t;

endpackage

// ===== rtl/rta_div.sv =====
module rta_div import rta_pkg::*; #(
  parameter int DW = SAMPLE_BITS_DEF + 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DW-1:0]        divisor_i,
  output rta_div_status_t      status_o,
  output logic [GAIN_W-1:0]    quot_o
);

  // Restoring division of the fixed gain numerator, one quotient bit per cycle.
  localparam int CNT_W = $clog2(GAIN_W + 1);

  logic              busy_q, done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DW-1:0]     rem_q, div_q;
  logic [GAIN_W-1:0] quot_q;

  logic [DW:0]       trial;
  logic [DW:0]       diff;
  logic              take;

  assign trial = {rem_q, quot_q[GAIN_W-1]};
  assign diff  = trial - {1'b0, div_q};
  assign take  = (trial >= {1'b0, div_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(GAIN_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      div_q  <= divisor_i;
      quot_q <= GAIN_NUMERATOR;
    end else if (busy_q) begin
      rem_q  <= take ? diff[DW-1:0] : trial[DW-1:0];
      quot_q <= {quot_q[GAIN_W-2:0], take};
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quot_o        = quot_q;

endmodule

// ===== rtl/rta_ring.sv =====
module rta_ring import rta_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   clr_i,
  input  logic                   wr_i,
  input  logic [SAMPLE_BITS-1:0] data_i,
  output logic                   full_o,
  output logic [SAMPLE_BITS+1:0] mid_sum_o
);

  // Four-entry sample ring; the sum of its two middle values is the sum of
  // all four less the smallest and the largest.
  logic [SAMPLE_BITS-1:0] ring_q [RING_DEPTH];
  logic [RING_IDX_W-1:0]  pos_q;
  logic                   full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      full_q <= 1'b0;
    end else if (clr_i) begin
      pos_q  <= '0;
      full_q <= 1'b0;
    end else if (wr_i) begin
      pos_q <= pos_q + 1'b1;
      if (pos_q == RING_IDX_W'(RING_DEPTH - 1)) begin
        full_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i && !clr_i) begin
      ring_q[pos_q] <= data_i;
    end
  end

  always_comb begin
    logic [SAMPLE_BITS-1:0] lo, hi;
    logic [SAMPLE_BITS+1:0] sum;
    lo  = ring_q[0];
    hi  = ring_q[0];
    sum = '0;
    for (int i = 0; i < RING_DEPTH; i++) begin
      if (ring_q[i] < lo) lo = ring_q[i];
      if (ring_q[i] > hi) hi = ring_q[i];
      sum = sum + (SAMPLE_BITS+2)'(ring_q[i]);
    end
    mid_sum_o = sum - (SAMPLE_BITS+2)'(lo) - (SAMPLE_BITS+2)'(hi);
  end

  assign full_o = full_q;

endmodule

// ===== rtl/relay_autotune.sv =====
// Channel   Direction  Handshake                  Content
// s_axis    in         s_axis_tvalid/tready       tdata: pv_sample; tuser: req_type
// m_axis    out        m_axis_tvalid/tready       tdata: drive, done, ok, gain, period, running
// cfg       in         cfg_valid/cfg_ready        cfg_index_i selects register, cfg_data_i
//
// One word is worked on at a time; s_axis_tready_o is high only when idle.
// A start, an idle tick or an ordinary tick passes from the execute step
// straight to the output step; a tick that writes the sample ring passes
// through the ring step as well, and a tick that completes tuning with a
// positive extreme difference waits in the divide step for the serial
// divider, which produces one quotient bit per cycle.
// Reset is asynchronous and active low; the result is held until taken, and
// configuration writes are accepted in every cycle.
module relay_autotune import rta_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // tdata: pv_sample from bit 0, zero padded to whole bytes.
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  // tuser: req_type.
  input  logic                     s_axis_tuser_i,
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  // tdata: drive_code [7:0], tune_done [8], tune_ok [9], gain_q8 [26:10],
  // period_ticks [40:27], running [41], zero padding above.
  output logic [OUT_TDATA_W-1:0]   m_axis_tdata_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic                     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int SUM_W = SAMPLE_BITS + 2;
  localparam int CMP_W = (SAMPLE_BITS > SETPOINT_W) ? SAMPLE_BITS : SETPOINT_W;
  localparam logic [SUM_W-1:0] LOW_PAIR_INIT = SUM_W'(1) << (SAMPLE_BITS + 1);

  // Configuration registers.
  logic [SETPOINT_W-1:0] setpoint_q;
  logic [TIMEOUT_W-1:0]  timeout_q;

  // Sequencer and the captured input word.
  rta_state_e            state_q, state_d;
  logic [SAMPLE_BITS-1:0] pv_q;
  logic                  req_q;

  // Tuning state.
  logic                  active_q, active_d;
  logic                  start_below_q, start_below_d;
  logic                  relay_q, relay_d;
  logic [VOTE_W-1:0]     heat_votes_q, heat_votes_d;
  logic [VOTE_W-1:0]     cool_votes_q, cool_votes_d;
  logic [CROSS_W-1:0]    cross_q, cross_d;
  logic [PERIOD_W-1:0]   tick_q, tick_d;
  logic [SUM_W-1:0]      low_sum_q, low_sum_d;
  logic [SUM_W-1:0]      high_sum_q, high_sum_d;
  logic [PERIOD_W-1:0]   low_time_q, low_time_d;
  logic [DRIVE_W-1:0]    drive_q, drive_d;
  logic [GAIN_W-1:0]     gain_q, gain_d;
  logic [PERIOD_W-1:0]   period_q, period_d;
  logic                  done_q, done_d;
  logic                  ok_q, ok_d;

  // Links to the ring and the divider.
  logic                  ring_clr, ring_wr, ring_full;
  logic [SUM_W-1:0]      mid_sum;
  logic                  div_start;
  rta_div_status_t       div_status;
  logic [GAIN_W-1:0]     div_quot;

  logic                  s_accept;
  logic                  sp_ge_pv;

  assign s_accept    = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o = 1'b1;
  assign sp_ge_pv    = CMP_W'(setpoint_q) >= CMP_W'(pv_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q <= SETPOINT_RESET;
      timeout_q  <= TIMEOUT_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SETPOINT: setpoint_q <= cfg_data_i[SETPOINT_W-1:0];
        REG_TIMEOUT:  timeout_q  <= cfg_data_i[TIMEOUT_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      pv_q  <= s_axis_tdata_i[SAMPLE_BITS-1:0];
      req_q <= s_axis_tuser_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      active_q      <= 1'b0;
      start_below_q <= 1'b0;
      relay_q       <= 1'b0;
      heat_votes_q  <= '0;
      cool_votes_q  <= '0;
      cross_q       <= '0;
      tick_q        <= '0;
      low_sum_q     <= LOW_PAIR_INIT;
      high_sum_q    <= '0;
      low_time_q    <= '0;
      drive_q       <= DRIVE_OFF;
      gain_q        <= GAIN_DEFAULT;
      period_q      <= PERIOD_DEFAULT;
      done_q        <= 1'b0;
      ok_q          <= 1'b0;
    end else begin
      state_q       <= state_d;
      active_q      <= active_d;
      start_below_q <= start_below_d;
      relay_q       <= relay_d;
      heat_votes_q  <= heat_votes_d;
      cool_votes_q  <= cool_votes_d;
      cross_q       <= cross_d;
      tick_q        <= tick_d;
      low_sum_q     <= low_sum_d;
      high_sum_q    <= high_sum_d;
      low_time_q    <= low_time_d;
      drive_q       <= drive_d;
      gain_q        <= gain_d;
      period_q      <= period_d;
      done_q        <= done_d;
      ok_q          <= ok_d;
    end
  end

  // Sequencer. The tick work is done in the execute step; the ring step
  // follows when a sample was stored, and the final crossing hands a positive
  // extreme difference to the divider.
  always_comb begin
    logic [PERIOD_W:0]   tick_next;
    logic [PERIOD_W-1:0] tick_new;
    logic [VOTE_W-1:0]   hv, cv;
    logic                relay_new, crossed;
    logic [CROSS_W-1:0]  cross_new;
    logic [PERIOD_W-1:0] low_time_new;
    logic [DRIVE_W-1:0]  drive_new;
    logic                low_phase;

    state_d       = state_q;
    active_d      = active_q;
    start_below_d = start_below_q;
    relay_d       = relay_q;
    heat_votes_d  = heat_votes_q;
    cool_votes_d  = cool_votes_q;
    cross_d       = cross_q;
    tick_d        = tick_q;
    low_sum_d     = low_sum_q;
    high_sum_d    = high_sum_q;
    low_time_d    = low_time_q;
    drive_d       = drive_q;
    gain_d        = gain_q;
    period_d      = period_q;
    done_d        = done_q;
    ok_d          = ok_q;
    ring_clr      = 1'b0;
    ring_wr       = 1'b0;
    div_start     = 1'b0;
    s_axis_tready_o = 1'b0;
    m_axis_tvalid_o = 1'b0;

    tick_next    = {1'b0, tick_q} + 1'b1;
    tick_new     = tick_next[PERIOD_W-1:0];
    hv           = heat_votes_q;
    cv           = cool_votes_q;
    relay_new    = relay_q;
    crossed      = 1'b0;
    drive_new    = drive_q;
    cross_new    = cross_q;
    low_time_new = low_time_q;
    low_phase    = ((cross_q == CROSS_RING_A) == start_below_q);

    unique case (state_q)
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        done_d  = 1'b0;
        ok_d    = 1'b0;
        state_d = S_OUT;
        if (req_q == REQ_START) begin
          start_below_d = sp_ge_pv;
          relay_d       = !sp_ge_pv;
          cross_d       = '0;
          tick_d        = '0;
          ring_clr      = 1'b1;
          low_sum_d     = LOW_PAIR_INIT;
          high_sum_d    = '0;
          low_time_d    = '0;
          active_d      = 1'b1;
        end else if (active_q) begin
          if (tick_next > {1'b0, timeout_q}) begin
            // Timed out: report failure with the default results.
            tick_d   = '0;
            gain_d   = GAIN_DEFAULT;
            period_d = PERIOD_DEFAULT;
            active_d = 1'b0;
            done_d   = 1'b1;
          end else begin
            tick_d = tick_new;
            if (sp_ge_pv) begin
              cv = '0;
              if (hv < VOTE_LIMIT) hv = hv + 1'b1;
              if (hv >= VOTE_LIMIT) begin
                drive_new = DRIVE_HEAT;
                if (!relay_q) begin
                  relay_new = 1'b1;
                  crossed   = 1'b1;
                end
              end
            end else begin
              hv = '0;
              if (cv < VOTE_LIMIT) cv = cv + 1'b1;
              if (cv >= VOTE_LIMIT) begin
                drive_new = DRIVE_OFF;
                if (relay_q) begin
                  relay_new = 1'b0;
                  crossed   = 1'b1;
                end
              end
            end
            if (crossed) begin
              cross_new = cross_q + 1'b1;
              if (cross_new == CROSS_RING_A) begin
                low_time_new = tick_new - CROSS_LAG;
              end
            end
            heat_votes_d = hv;
            cool_votes_d = cv;
            relay_d      = relay_new;
            drive_d      = drive_new;
            cross_d      = cross_new;
            low_time_d   = low_time_new;

            if (cross_new == CROSS_RING_A || cross_new == CROSS_RING_B) begin
              ring_wr = 1'b1;
              state_d = S_RING;
            end else if (cross_new == CROSS_FINAL) begin
              cross_d  = '0;
              active_d = 1'b0;
              done_d   = 1'b1;
              if (high_sum_q > low_sum_q) begin
                period_d  = tick_new - CROSS_LAG - low_time_q;
                div_start = 1'b1;
                state_d   = S_DIV;
              end else begin
                gain_d   = GAIN_DEFAULT;
                period_d = PERIOD_DEFAULT;
              end
            end
          end
        end
      end

      S_RING: begin
        if (ring_full) begin
          if (low_phase) begin
            if (mid_sum <= low_sum_q) low_sum_d = mid_sum;
          end else begin
            if (mid_sum >= high_sum_q) high_sum_d = mid_sum;
          end
        end
        state_d = S_OUT;
      end

      S_DIV: begin
        if (div_status.done) begin
          gain_d  = div_quot;
          ok_d    = 1'b1;
          state_d = S_OUT;
        end
      end

      S_OUT: begin
        m_axis_tvalid_o = 1'b1;
        if (m_axis_tready_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  rta_ring #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (ring_clr),
    .wr_i      (ring_wr),
    .data_i    (pv_q),
    .full_o    (ring_full),
    .mid_sum_o (mid_sum)
  );

  rta_div #(
    .DW (SUM_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (high_sum_q - low_sum_q),
    .status_o  (div_status),
    .quot_o    (div_quot)
  );

  // The result word is built from the held state, which does not move while
  // the word waits to be taken.
  assign m_axis_tdata_o = OUT_TDATA_W'({active_q, period_q, gain_q, ok_q, done_q, drive_q});

  // Only one word is in the block at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !m_axis_tvalid_o)
    else $error("input taken while a result is pending");

  // A successful result always marks the end of tuning.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && ok_q) |-> done_q)
    else $error("tune_ok without tune_done");

  // The divider finishes only while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_status.done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide step");

  // The crossing count never runs past the final crossing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cross_q <= CROSS_FINAL)
    else $error("crossing count out of range");

  // No tuning run is left active once it has reported completion.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && done_q) |-> !active_q)
    else $error("run still active after completion");

endmodule

// ===== tb/tb.sv =====
module tb;
  import rta_pkg::*;

  localparam int SB         = SAMPLE_BITS_DEF;
  localparam int IN_W       = ((SB + 7) / 8) * 8;
  localparam int SAMPLE_MAX = (1 << SB) - 1;
  localparam int WORD_GOAL  = 1850;
  localparam int LONG_HOLD  = 400;

  localparam logic [SB+1:0] LOW_SUM_INIT = {1'b1, {(SB + 1){1'b0}}};

  // One result word as it leaves the block, lowest field in the lowest bits.
  typedef struct packed {
    logic                running;
    logic [PERIOD_W-1:0] period;
    logic [GAIN_W-1:0]   gain;
    logic                ok;
    logic                done;
    logic [DRIVE_W-1:0]  drive;
  } tune_word_t;

  typedef enum logic {
    ROW_WORD,
    ROW_REG
  } row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic                  req;
    logic [SB-1:0]         pv;
    logic                  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    bit                    typed;
    tune_word_t            want;
  } plan_row_t;

  logic                   clk_i;
  logic                   rst_ni    = 1'b0;
  logic                   s_valid   = 1'b0;
  logic [IN_W-1:0]        s_tdata   = '0;
  logic                   s_tuser   = REQ_START;
  logic                   m_ready   = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_index = REG_SETPOINT;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   s_ready;
  logic                   m_valid;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_ready;

  relay_autotune u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Our own copy of the tuner, reset values as after power-up.
  logic [SETPOINT_W-1:0] cfg_setpoint = SETPOINT_RESET;
  logic [TIMEOUT_W-1:0]  cfg_timeout  = TIMEOUT_RESET;
  logic                  tuning       = 1'b0;
  logic                  began_below  = 1'b0;
  logic                  heater_on    = 1'b0;
  logic [VOTE_W-1:0]     heat_votes   = '0;
  logic [VOTE_W-1:0]     cool_votes   = '0;
  logic [CROSS_W-1:0]    cross_count  = '0;
  logic [PERIOD_W-1:0]   ticks        = '0;
  logic [SB-1:0]         ring [RING_DEPTH] = '{default: '0};
  logic [RING_IDX_W-1:0] ring_wr      = '0;
  logic                  ring_full    = 1'b0;
  logic [SB+1:0]         low_sum      = LOW_SUM_INIT;
  logic [SB+1:0]         high_sum     = '0;
  logic [PERIOD_W-1:0]   low_mark     = '0;
  logic [DRIVE_W-1:0]    drive_now    = DRIVE_OFF;
  logic [GAIN_W-1:0]     gain_now     = GAIN_DEFAULT;
  logic [PERIOD_W-1:0]   period_now   = PERIOD_DEFAULT;

  tune_word_t expected_words[$];
  int         mismatches   = 0;
  int         sent_words   = 0;
  int         tx_burst     = 0;
  int         rx_burst     = 0;

  // A relay change is a setpoint crossing; the third one marks the start of
  // the period measurement, three ticks back to allow for the vote delay.
  function automatic void note_crossing();
    cross_count = cross_count + 1'b1;
    if (cross_count == CROSS_RING_A) low_mark = ticks - CROSS_LAG;
  endfunction

  function automatic tune_word_t predict_tune(input logic req, input logic [SB-1:0] pv);
    tune_word_t r;
    int         total;
    int         lo;
    int         hi;
    int         mid;
    logic       finished;
    logic       success;
    logic       low_phase;
    finished = 1'b0;
    success  = 1'b0;
    if (req == REQ_START) begin
      began_below = (cfg_setpoint >= pv);
      heater_on   = !began_below;
      cross_count = '0;
      ticks       = '0;
      ring_wr     = '0;
      ring_full   = 1'b0;
      low_sum     = LOW_SUM_INIT;
      high_sum    = '0;
      low_mark    = '0;
      tuning      = 1'b1;
    end else if (tuning) begin
      if (int'(ticks) + 1 > int'(cfg_timeout)) begin
        // Ran out of time: defaults reported, the rest of the tick is skipped.
        ticks      = '0;
        gain_now   = GAIN_DEFAULT;
        period_now = PERIOD_DEFAULT;
        tuning     = 1'b0;
        finished   = 1'b1;
      end else begin
        ticks = ticks + 1'b1;
        if (cfg_setpoint >= pv) begin
          cool_votes = '0;
          if (heat_votes < VOTE_LIMIT) heat_votes = heat_votes + 1'b1;
          if (heat_votes >= VOTE_LIMIT) begin
            drive_now = DRIVE_HEAT;
            if (!heater_on) begin
              heater_on = 1'b1;
              note_crossing();
            end
          end
        end else begin
          heat_votes = '0;
          if (cool_votes < VOTE_LIMIT) cool_votes = cool_votes + 1'b1;
          if (cool_votes >= VOTE_LIMIT) begin
            drive_now = DRIVE_OFF;
            if (heater_on) begin
              heater_on = 1'b0;
              note_crossing();
            end
          end
        end
        if (cross_count == CROSS_RING_A || cross_count == CROSS_RING_B) begin
          ring[ring_wr] = pv;
          ring_wr = ring_wr + 1'b1;
          if (ring_wr == '0) ring_full = 1'b1;
          if (ring_full) begin
            total = 0;
            lo    = int'(ring[0]);
            hi    = int'(ring[0]);
            for (int i = 0; i < RING_DEPTH; i++) begin
              if (ring[i] < lo) lo = int'(ring[i]);
              if (ring[i] > hi) hi = int'(ring[i]);
              total += int'(ring[i]);
            end
            mid = total - lo - hi;
            low_phase = ((cross_count == CROSS_RING_A) == began_below);
            if (low_phase) begin
              if (mid <= int'(low_sum)) low_sum = (SB + 2)'(mid);
            end else if (mid >= int'(high_sum)) begin
              high_sum = (SB + 2)'(mid);
            end
          end
        end else if (cross_count == CROSS_FINAL) begin
          cross_count = '0;
          tuning      = 1'b0;
          finished    = 1'b1;
          if (high_sum > low_sum) begin
            gain_now   = GAIN_NUMERATOR / (high_sum - low_sum);
            period_now = ticks - CROSS_LAG - low_mark;
            success    = 1'b1;
          end else begin
            gain_now   = GAIN_DEFAULT;
            period_now = PERIOD_DEFAULT;
          end
        end
      end
    end
    r.drive   = drive_now;
    r.done    = finished;
    r.ok      = success;
    r.gain    = gain_now;
    r.period  = period_now;
    r.running = tuning;
    return r;
  endfunction

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= 100) $display("mismatch: %s", msg);
  endtask

  // Gap before the next word on either side; now and then a run of words
  // goes through with no gap at all.
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      burst = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  // Offers one word, waits for the handshake and records what must come back.
  // The valid line is left high only when the next word follows at once.
  task automatic send_word(input logic req, input logic [SB-1:0] pv,
                           input bit typed = 1'b0, input tune_word_t want = '0);
    tune_word_t predicted;
    int         gap;
    s_valid <= 1'b1;
    s_tuser <= req;
    s_tdata <= IN_W'(pv);
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    sent_words++;
    predicted = predict_tune(req, pv);
    expected_words.push_back(typed ? want : predicted);
    gap = draw_gap(tx_burst);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Registers change only once every result word has been taken.
  task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] val);
    s_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    if (idx == REG_SETPOINT) cfg_setpoint = val[SETPOINT_W-1:0];
    else cfg_timeout = val[TIMEOUT_W-1:0];
  endtask

  // A sample on the chosen side: at most amp under the setpoint, or 1 to amp+1 over it (only under at the ceiling).
  function automatic logic [SB-1:0] level(input bit below, input int amp);
    int sp;
    sp = int'(cfg_setpoint);
    if (below || sp == SAMPLE_MAX) return SB'(sp - $urandom_range(0, (amp < sp) ? amp : sp));
    return SB'(sp + 1 + $urandom_range(0, (amp < SAMPLE_MAX - 1 - sp) ? amp : SAMPLE_MAX - 1 - sp));
  endfunction

  // A start followed by a square wave around the setpoint. Most runs go
  // through all five crossings; some stop early or carry single-sample
  // glitches that reset the vote counters. Half periods of exactly four
  // samples with a small swing tend to give no extreme difference at all.
  task automatic tune_run();
    int  amp;
    int  halves;
    int  half_len;
    bit  square;
    bit  side;
    side   = $urandom_range(0, 1);
    square = ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 3))
      0:       amp = 0;
      1:       amp = $urandom_range(1, 3);
      default: amp = $urandom_range(0, SAMPLE_MAX);
    endcase
    halves = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 5;
    send_word(REQ_START, level(side, amp));
    for (int h = 0; h < halves; h++) begin
      half_len = square ? 4 : $urandom_range(4, 10);
      for (int k = 0; k < half_len; k++) begin
        if (!square && $urandom_range(0, 29) == 0) send_word(REQ_TICK, level(!side, amp));
        else send_word(REQ_TICK, level(side, amp));
      end
      side = !side;
    end
  endtask

  function automatic plan_row_t item_row(input logic req, input logic [SB-1:0] pv);
    plan_row_t r;
    r = '{kind: ROW_WORD, req: req, pv: pv, reg_idx: REG_SETPOINT, reg_val: '0,
          typed: 1'b0, want: '0};
    return r;
  endfunction

  function automatic plan_row_t checked_row(input logic req, input logic [SB-1:0] pv,
                                            input tune_word_t want);
    plan_row_t r;
    r = item_row(req, pv);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic plan_row_t reg_row(input logic idx, input logic [CFG_DATA_W-1:0] val);
    plan_row_t r;
    r = item_row(REQ_START, '0);
    r.kind    = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // Stimulus: a short directed plan, then random phases under several
  // register settings.
  initial begin : stimulus
    plan_row_t  plan[$];
    tune_word_t quiet;
    tune_word_t started;
    tune_word_t timed_out;
    int         phase_end;
    int         share;
    logic [SETPOINT_W-1:0] sp;
    logic [TIMEOUT_W-1:0]  limit;

    quiet = '{running: 1'b0, period: PERIOD_DEFAULT, gain: GAIN_DEFAULT,
              ok: 1'b0, done: 1'b0, drive: DRIVE_OFF};
    started = quiet;
    started.running = 1'b1;
    timed_out = quiet;
    timed_out.done = 1'b1;

    // A tick before any start is ignored and shows the reset values.
    plan.push_back(checked_row(REQ_TICK, '0, quiet));
    plan.push_back(checked_row(REQ_START, SB'(SAMPLE_MAX), started));
    // A second start while running restarts the run.
    plan.push_back(checked_row(REQ_START, '0, started));
    // With a limit of one tick the second tick times out.
    plan.push_back(reg_row(REG_TIMEOUT, 14'd1));
    plan.push_back(item_row(REQ_TICK, '0));
    plan.push_back(checked_row(REQ_TICK, '0, timed_out));
    // Setpoint at its floor, longest limit: a square wave of four samples per
    // side swinging by one step, which ends with no extreme difference.
    plan.push_back(reg_row(REG_TIMEOUT, 14'd16383));
    plan.push_back(reg_row(REG_SETPOINT, 14'd0));
    plan.push_back(item_row(REQ_START, '0));
    for (int i = 0; i < 20; i++) plan.push_back(item_row(REQ_TICK, SB'((i / 4) % 2)));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) write_reg(plan[i].reg_idx, plan[i].reg_val);
      else send_word(plan[i].req, plan[i].pv, plan[i].typed, plan[i].want);
    end

    // Random phases: setpoint at the ceiling, a one-tick limit, a short limit
    // that makes timeouts common, then ordinary settings.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          sp    = SETPOINT_W'(SAMPLE_MAX);
          limit = 14'd16383;
          share = 120;
        end
        1: begin
          sp    = '0;
          limit = 14'd1;
          share = 120;
        end
        2: begin
          sp    = SETPOINT_W'($urandom_range(100, 4000));
          limit = TIMEOUT_W'($urandom_range(20, 60));
          share = 260;
        end
        default: begin
          sp    = SETPOINT_W'($urandom_range(1, SAMPLE_MAX - 1));
          limit = $urandom_range(0, 1) ? 14'd16383 : TIMEOUT_W'($urandom_range(60, 16383));
          share = 270;
        end
      endcase
      write_reg(REG_SETPOINT, CFG_DATA_W'(sp));
      write_reg(REG_TIMEOUT, limit);
      phase_end = sent_words + share;
      while (sent_words < phase_end) begin
        if ($urandom_range(0, 3) != 0) begin
          tune_run();
        end else begin
          repeat ($urandom_range(1, 6)) begin
            send_word(($urandom_range(0, 4) == 0) ? REQ_START : REQ_TICK,
                      SB'($urandom_range(0, SAMPLE_MAX)));
          end
        end
      end
    end

    s_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    // Anything arriving now would be a word nobody asked for.
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // Result side: random stalls, and once a long hold-off so that the block
  // holds its result, stops taking words and the sender is left waiting.
  initial begin : result_sink
    tune_word_t got;
    tune_word_t want;
    int         stall;
    int         taken;
    bit         held_long;
    taken     = 0;
    held_long = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held_long && taken == 500) begin
        stall     = LONG_HOLD;
        held_long = 1'b1;
      end else begin
        stall = draw_gap(rx_burst);
      end
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      @(posedge clk_i);
      while (!m_valid) @(posedge clk_i);
      got = tune_word_t'(m_tdata[OUT_BITS-1:0]);
      if (expected_words.size() == 0) begin
        report($sformatf("word %0d arrived with nothing expected", taken));
      end else begin
        want = expected_words.pop_front();
        if (got.drive !== want.drive)
          report($sformatf("word %0d drive_code %0d, expected %0d", taken, got.drive, want.drive));
        if (got.done !== want.done)
          report($sformatf("word %0d tune_done %0b, expected %0b", taken, got.done, want.done));
        if (got.ok !== want.ok)
          report($sformatf("word %0d tune_ok %0b, expected %0b", taken, got.ok, want.ok));
        if (got.gain !== want.gain)
          report($sformatf("word %0d gain_q8 %0d, expected %0d", taken, got.gain, want.gain));
        if (got.period !== want.period)
          report($sformatf("word %0d period_ticks %0d, expected %0d", taken, got.period,
                           want.period));
        if (got.running !== want.running)
          report($sformatf("word %0d running %0b, expected %0b", taken, got.running,
                           want.running));
      end
      taken++;
    end
  end

  // Watchdog. Its limit is well over five times the length of a correct run,
  // even with both sides stalling their longest around a completing divide.
  initial begin : watchdog
    #8_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
